// ===== sv/fbsg_pkg.sv =====
// Shared types, codes and constants for the FAT32 boot sector geometry block.
`timescale 1ns / 1ps
`default_nettype none

package fbsg_pkg;

  localparam int SECTOR_IMAGE_BYTES_DEF = 512;
  localparam int Q_DEPTH = 2;

  localparam logic [15:0] SIG_WORD = 16'hAA55;

  localparam int OFS_BPS_LO = 11;
  localparam int OFS_BPS_HI = 12;
  localparam int OFS_SPC    = 13;
  localparam int OFS_RSV_LO = 14;
  localparam int OFS_RSV_HI = 15;
  localparam int OFS_FATS   = 16;
  localparam int OFS_FATSZ  = 36;
  localparam int OFS_ROOT   = 44;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIG   = 3'd1;
  localparam logic [2:0] ST_ALREADY   = 3'd2;
  localparam logic [2:0] ST_SECTOR    = 3'd3;
  localparam logic [2:0] ST_NOT_VALID = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_PARSE  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [27:0] cluster;
    logic [15:0] reserved;
    logic [7:0]  fat_copies;
    logic [31:0] fat_size;
    logic [7:0]  spc;
    logic [15:0] bps;
    logic [31:0] root;
  } fbsg_cmd_t;

endpackage

`default_nettype wire

// ===== sv/fbsg_front.sv =====
// Front end: accepts items, tracks the byte position, captures boot sector fields, classifies.
`timescale 1ns / 1ps
`default_nettype none

module fbsg_front
  import fbsg_pkg::*;
#(
  parameter int SECTOR_IMAGE_BYTES = SECTOR_IMAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  data_byte,
  input  wire logic [27:0] cluster,
  input  wire logic        q_full,
  output logic             push,
  output fbsg_cmd_t        cmd
);

  localparam int PW = $clog2(SECTOR_IMAGE_BYTES);
  localparam logic [PW-1:0] LAST_POS = PW'(SECTOR_IMAGE_BYTES - 1);
  localparam logic [PW-1:0] SIG_POS  = PW'(SECTOR_IMAGE_BYTES - 2);

  logic [PW-1:0] byte_pos;
  logic          volume_valid;
  logic [15:0]   bps;
  logic [7:0]    spc;
  logic [15:0]   rsv;
  logic [7:0]    fats;
  logic [31:0]   fat_size;
  logic [31:0]   root;
  logic [7:0]    sig_low;

  logic accept;
  logic last;
  logic sig_ok;
  logic push_req;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign last     = byte_pos == LAST_POS;
  assign sig_ok   = {data_byte, sig_low} == SIG_WORD;
  assign push     = accept && push_req;

  always_comb begin
    push_req       = 1'b0;
    cmd.kind       = KIND_STATUS;
    cmd.status     = ST_OK;
    cmd.cluster    = cluster;
    cmd.reserved   = rsv;
    cmd.fat_copies = fats;
    cmd.fat_size   = fat_size;
    cmd.spc        = spc;
    cmd.bps        = bps;
    cmd.root       = root;
    case (func)
      FUNC_BYTE: begin
        if (last) begin
          push_req = 1'b1;
          if (volume_valid) begin
            cmd.status = ST_ALREADY;
          end else if (!sig_ok) begin
            cmd.status = ST_BAD_SIG;
          end else begin
            cmd.kind   = KIND_PARSE;
            cmd.status = ST_OK;
          end
        end
      end
      FUNC_QUERY: begin
        push_req = 1'b1;
        if (volume_valid) begin
          cmd.kind   = KIND_QUERY;
          cmd.status = ST_SECTOR;
        end else begin
          cmd.status = ST_NOT_VALID;
        end
      end
      default: begin
        push_req = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos     <= '0;
      volume_valid <= 1'b0;
    end else if (accept) begin
      case (func)
        FUNC_BYTE: begin
          byte_pos <= last ? '0 : byte_pos + PW'(1);
          if (last && !volume_valid && sig_ok) begin
            volume_valid <= 1'b1;
          end
        end
        FUNC_CLEAR: begin
          byte_pos     <= '0;
          volume_valid <= 1'b0;
        end
        default: begin
          byte_pos <= byte_pos;
        end
      endcase
    end
  end

  // Capture little-endian fields while no volume is mounted
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_BYTE && !volume_valid) begin
      if (byte_pos == PW'(OFS_BPS_LO)) bps[7:0] <= data_byte;
      if (byte_pos == PW'(OFS_BPS_HI)) bps[15:8] <= data_byte;
      if (byte_pos == PW'(OFS_SPC)) spc <= data_byte;
      if (byte_pos == PW'(OFS_RSV_LO)) rsv[7:0] <= data_byte;
      if (byte_pos == PW'(OFS_RSV_HI)) rsv[15:8] <= data_byte;
      if (byte_pos == PW'(OFS_FATS)) fats <= data_byte;
      if (byte_pos >= PW'(OFS_FATSZ) && byte_pos < PW'(OFS_FATSZ + 4)) begin
        case (byte_pos[1:0])
          2'd0:    fat_size[7:0]   <= data_byte;
          2'd1:    fat_size[15:8]  <= data_byte;
          2'd2:    fat_size[23:16] <= data_byte;
          default: fat_size[31:24] <= data_byte;
        endcase
      end
      if (byte_pos >= PW'(OFS_ROOT) && byte_pos < PW'(OFS_ROOT + 4)) begin
        case (byte_pos[1:0])
          2'd0:    root[7:0]   <= data_byte;
          2'd1:    root[15:8]  <= data_byte;
          2'd2:    root[23:16] <= data_byte;
          default: root[31:24] <= data_byte;
        endcase
      end
      if (byte_pos == SIG_POS) sig_low <= data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fbsg_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module fbsg_queue
  import fbsg_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire fbsg_cmd_t cmd_in,
  input  wire logic      pop,
  output fbsg_cmd_t      cmd_out,
  output logic           full,
  output logic           not_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fbsg_cmd_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign cmd_out   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== sv/fbsg_back.sv =====
// Back end: computes geometry and cluster sectors with one shared multiplier, holds the result.
`timescale 1ns / 1ps
`default_nettype none

module fbsg_back
  import fbsg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        q_valid,
  input  wire fbsg_cmd_t   cmd,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [31:0]      sector,
  output logic [31:0]      fat_start,
  output logic [31:0]      data_start,
  output logic [7:0]       cluster_sectors,
  output logic [15:0]      sector_bytes,
  output logic [31:0]      root_cluster
);

  logic [31:0] partition_start;
  logic [31:0] data_start_reg;
  logic [7:0]  spc_reg;

  logic [31:0] mul_a;
  logic [7:0]  mul_b;
  logic [39:0] prod;
  logic [31:0] fat_st;
  logic [31:0] data_st;
  logic [31:0] query_sector;
  logic        is_query;

  assign pop      = q_valid && (!out_valid || out_ready);
  assign is_query = cmd.kind == KIND_QUERY;

  always_comb begin
    mul_a        = is_query ? ({4'b0, cmd.cluster} - 32'd2) : cmd.fat_size;
    mul_b        = is_query ? spc_reg : cmd.fat_copies;
    prod         = mul_a * mul_b;
    fat_st       = partition_start + {16'b0, cmd.reserved};
    data_st      = fat_st + prod[31:0];
    query_sector = data_start_reg + prod[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_start <= '0;
    end else if (cfg_we) begin
      partition_start <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status <= cmd.status;
      case (cmd.kind)
        KIND_PARSE: begin
          sector          <= '0;
          fat_start       <= fat_st;
          data_start      <= data_st;
          cluster_sectors <= cmd.spc;
          sector_bytes    <= cmd.bps;
          root_cluster    <= cmd.root;
          data_start_reg  <= data_st;
          spc_reg         <= cmd.spc;
        end
        KIND_QUERY: begin
          sector          <= query_sector;
          fat_start       <= '0;
          data_start      <= '0;
          cluster_sectors <= '0;
          sector_bytes    <= '0;
          root_cluster    <= '0;
        end
        default: begin
          sector          <= '0;
          fat_start       <= '0;
          data_start      <= '0;
          cluster_sectors <= '0;
          sector_bytes    <= '0;
          root_cluster    <= '0;
        end
      endcase
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_SECTOR |-> sector == '0)
    else $error("sector set on a non-query result");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> fat_start == '0 && data_start == '0 &&
      cluster_sectors == '0 && sector_bytes == '0 && root_cluster == '0)
    else $error("geometry set on a result other than parsed ok");
`endif

endmodule

`default_nettype wire

// ===== sv/fat32_boot_sector_geometry_top.sv =====
// Top level of the FAT32 boot sector geometry parser and cluster-to-sector mapper.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one item per cycle while the command queue has room: boot sector bytes in
// order from offset 0, cluster queries and clear items. A result is registered at the
// output once its item leaves the queue and can wait on out_ready while further items keep
// coming; a two-entry command queue between the byte parser and the arithmetic stage
// absorbs the stall before in_ready drops. The arithmetic stage has one 32x8 multiplier,
// shared by the data start computation at the end of a parse and by cluster queries.
// partition_start is sampled when the last byte of a parse reaches the arithmetic stage.
module fat32_boot_sector_geometry_top
  import fbsg_pkg::*;
#(
  parameter int SECTOR_IMAGE_BYTES = SECTOR_IMAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  data_byte,
  input  wire logic [27:0] cluster,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [31:0]      sector,
  output logic [31:0]      fat_start,
  output logic [31:0]      data_start,
  output logic [7:0]       cluster_sectors,
  output logic [15:0]      sector_bytes,
  output logic [31:0]      root_cluster
);

  fbsg_cmd_t push_cmd;
  fbsg_cmd_t head_cmd;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  fbsg_front #(
    .SECTOR_IMAGE_BYTES(SECTOR_IMAGE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .data_byte(data_byte),
    .cluster  (cluster),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  fbsg_queue #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd_in   (push_cmd),
    .pop      (pop),
    .cmd_out  (head_cmd),
    .full     (q_full),
    .not_empty(q_valid)
  );

  fbsg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .cmd            (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .sector         (sector),
    .fat_start      (fat_start),
    .data_start     (data_start),
    .cluster_sectors(cluster_sectors),
    .sector_bytes   (sector_bytes),
    .root_cluster   (root_cluster)
  );

endmodule

`default_nettype wire

// ===== tb/fat32_geometry_checker.sv =====
// Checker that predicts and compares the results of the FAT32 boot sector geometry block.
`timescale 1ns / 1ps

module fat32_geometry_checker
  import fbsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  input  logic [27:0] cluster,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [31:0] sector,
  input  logic [31:0] fat_start,
  input  logic [31:0] data_start,
  input  logic [7:0]  cluster_sectors,
  input  logic [15:0] sector_bytes,
  input  logic [31:0] root_cluster,
  output int          errors,
  output int          outstanding
);

  localparam logic [8:0] LAST_POS = 9'(SECTOR_IMAGE_BYTES_DEF - 1);
  localparam logic [8:0] SIG_POS  = 9'(SECTOR_IMAGE_BYTES_DEF - 2);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] sector;
    logic [31:0] fat_start;
    logic [31:0] data_start;
    logic [7:0]  cluster_sectors;
    logic [15:0] sector_bytes;
    logic [31:0] root_cluster;
  } geometry_result_t;

  geometry_result_t expected_results[$];

  logic [31:0] part_start;
  logic [8:0]  byte_pos;
  logic        vol_valid;
  logic [15:0] bps_q;
  logic [7:0]  spc_q;
  logic [15:0] rsv_q;
  logic [7:0]  fats_q;
  logic [31:0] fat_size_q;
  logic [31:0] root_q;
  logic [7:0]  sig_low_q;
  logic [31:0] fat_start_q;
  logic [31:0] data_start_q;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  function automatic void capture_byte(input logic [8:0] pos, input logic [7:0] b);
    if (pos == OFS_BPS_LO) bps_q[7:0] = b;
    else if (pos == OFS_BPS_HI) bps_q[15:8] = b;
    else if (pos == OFS_SPC) spc_q = b;
    else if (pos == OFS_RSV_LO) rsv_q[7:0] = b;
    else if (pos == OFS_RSV_HI) rsv_q[15:8] = b;
    else if (pos == OFS_FATS) fats_q = b;
    else if (pos >= OFS_FATSZ && pos < OFS_FATSZ + 4)
      fat_size_q[(pos - OFS_FATSZ) * 8 +: 8] = b;
    else if (pos >= OFS_ROOT && pos < OFS_ROOT + 4)
      root_q[(pos - OFS_ROOT) * 8 +: 8] = b;
    else if (pos == SIG_POS) sig_low_q = b;
  endfunction

  function automatic void step_volume(input logic [1:0] f, input logic [7:0] b,
                                      input logic [27:0] c);
    geometry_result_t r;
    logic [8:0] pos;
    r = '0;
    case (f)
      FUNC_BYTE: begin
        pos = byte_pos;
        if (!vol_valid) capture_byte(pos, b);
        if (pos != LAST_POS) begin
          byte_pos = pos + 9'd1;
        end else begin
          byte_pos = '0;
          if (vol_valid) begin
            r.status = ST_ALREADY;
          end else if ({b, sig_low_q} != SIG_WORD) begin
            r.status = ST_BAD_SIG;
          end else begin
            fat_start_q = part_start + {16'd0, rsv_q};
            data_start_q = fat_start_q + {24'd0, fats_q} * fat_size_q;
            vol_valid = 1'b1;
            r.status = ST_OK;
            r.fat_start = fat_start_q;
            r.data_start = data_start_q;
            r.cluster_sectors = spc_q;
            r.sector_bytes = bps_q;
            r.root_cluster = root_q;
          end
          expected_results.push_back(r);
        end
      end
      FUNC_QUERY: begin
        if (!vol_valid) begin
          r.status = ST_NOT_VALID;
        end else begin
          r.status = ST_SECTOR;
          r.sector = data_start_q + ({4'd0, c} - 32'd2) * {24'd0, spc_q};
        end
        expected_results.push_back(r);
      end
      FUNC_CLEAR: begin
        vol_valid = 1'b0;
        byte_pos = '0;
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    geometry_result_t want;
    if (rst) begin
      expected_results.delete();
      errors = 0;
      part_start = '0;
      byte_pos = '0;
      vol_valid = 1'b0;
      bps_q = '0;
      spc_q = '0;
      rsv_q = '0;
      fats_q = '0;
      fat_size_q = '0;
      root_q = '0;
      sig_low_q = '0;
      fat_start_q = '0;
      data_start_q = '0;
    end else begin
      if (cfg_we) part_start = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item waiting");
        end else begin
          want = expected_results.pop_front();
          check_field("status", status, want.status);
          check_field("sector", sector, want.sector);
          check_field("fat_start", fat_start, want.fat_start);
          check_field("data_start", data_start, want.data_start);
          check_field("cluster_sectors", cluster_sectors, want.cluster_sectors);
          check_field("sector_bytes", sector_bytes, want.sector_bytes);
          check_field("root_cluster", root_cluster, want.root_cluster);
        end
      end
      if (in_valid && in_ready) step_volume(func, data_byte, cluster);
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== tb/fat32_boot_sector_geometry_top_tb.sv =====
// Testbench top: drives boot sectors, cluster queries and clears into the geometry block.
`timescale 1ns / 1ps

module fat32_boot_sector_geometry_top_tb;
  import fbsg_pkg::*;

  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
  localparam logic [27:0] CLUSTER_MAX   = 28'hFFFFFFF;
  localparam int          QUIET_LIMIT   = 3000;
  localparam int          SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [27:0] cluster;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [31:0] sector;
  logic [31:0] fat_start;
  logic [31:0] data_start;
  logic [7:0]  cluster_sectors;
  logic [15:0] sector_bytes;
  logic [31:0] root_cluster;
  int          errors;
  int          outstanding;
  int          quiet_cycles;
  bit          steady;
  logic [7:0]  image [0:SECTOR_IMAGE_BYTES_DEF-1];

  fat32_boot_sector_geometry_top uut (.*);

  fat32_geometry_checker geometry_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    int pick;
    int hold;
    logic level;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        level = 1'b1;
        hold = $urandom_range(100, 300);
      end else if (pick < 65) begin
        level = 1'b1;
        hold = $urandom_range(1, 20);
      end else if (pick < 95) begin
        level = 1'b0;
        hold = $urandom_range(1, 4);
      end else begin
        level = 1'b0;
        hold = $urandom_range(10, 40);
      end
      out_ready <= level;
      repeat (hold) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [27:0] rand_cluster();
    case ($urandom_range(0, 5))
      0: return 28'($urandom_range(0, 3));
      1: return CLUSTER_MAX;
      default: return 28'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] f, input logic [7:0] b, input logic [27:0] c);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    data_byte <= b;
    cluster <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_partition_start(input logic [31:0] value);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic build_image(input bit good_sig);
    logic [31:0] bps;
    logic [31:0] spc;
    logic [31:0] rsv;
    logic [31:0] fats;
    logic [31:0] fsz;
    logic [31:0] root;
    logic [15:0] sig;
    int kind;
    for (int i = 0; i < SECTOR_IMAGE_BYTES_DEF; i++) image[i] = 8'($urandom);
    bps = pick_field();
    spc = pick_field();
    rsv = pick_field();
    fats = pick_field();
    fsz = pick_field();
    root = pick_field();
    image[OFS_BPS_LO] = bps[7:0];
    image[OFS_BPS_HI] = bps[15:8];
    image[OFS_SPC] = spc[7:0];
    image[OFS_RSV_LO] = rsv[7:0];
    image[OFS_RSV_HI] = rsv[15:8];
    image[OFS_FATS] = fats[7:0];
    for (int k = 0; k < 4; k++) begin
      image[OFS_FATSZ + k] = fsz[k*8 +: 8];
      image[OFS_ROOT + k] = root[k*8 +: 8];
    end
    if (good_sig) begin
      sig = SIG_WORD;
    end else begin
      kind = $urandom_range(0, 2);
      sig = 16'($urandom);
      if (kind == 0) sig[7:0] = SIG_WORD[7:0];
      if (kind == 1) sig[15:8] = SIG_WORD[15:8];
      if (sig == SIG_WORD) sig[0] = ~sig[0];
    end
    image[SECTOR_IMAGE_BYTES_DEF - 2] = sig[7:0];
    image[SECTOR_IMAGE_BYTES_DEF - 1] = sig[15:8];
  endtask

  task automatic send_sector(input int query_pct, input int pause_at);
    for (int i = 0; i < SECTOR_IMAGE_BYTES_DEF; i++) begin
      if (i == pause_at) drain_results();
      if ($urandom_range(0, 99) < query_pct)
        send_item(FUNC_QUERY, 8'($urandom), rand_cluster());
      if ($urandom_range(0, 99) == 0)
        send_item(FUNC_UNUSED, 8'($urandom), 28'($urandom));
      send_item(FUNC_BYTE, image[i], 28'($urandom));
    end
  endtask

  task automatic query_burst(input int count);
    logic [27:0] corners [4];
    corners = '{28'd0, 28'd1, 28'd2, CLUSTER_MAX};
    foreach (corners[k]) send_item(FUNC_QUERY, 8'($urandom), corners[k]);
    repeat (count) begin
      if ($urandom_range(0, 99) < 3) send_item(FUNC_UNUSED, 8'($urandom), 28'($urandom));
      send_item(FUNC_QUERY, 8'($urandom), rand_cluster());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    func = FUNC_BYTE;
    data_byte = '0;
    cluster = '0;
    steady = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(FUNC_QUERY, 8'h00, 28'd0);
    send_item(FUNC_QUERY, 8'hFF, CLUSTER_MAX);
    send_item(FUNC_QUERY, 8'h00, 28'd1);
    send_item(FUNC_QUERY, 8'h5A, 28'd2);
    send_item(FUNC_UNUSED, 8'hFF, CLUSTER_MAX);
    send_item(FUNC_CLEAR, 8'hFF, CLUSTER_MAX);
    send_item(FUNC_BYTE, 8'h00, 28'd0);
    send_item(FUNC_BYTE, 8'hFF, CLUSTER_MAX);
    send_item(FUNC_BYTE, 8'hFF, 28'd0);
    send_item(FUNC_QUERY, 8'h00, 28'd3);
    send_item(FUNC_CLEAR, 8'h00, 28'd0);
    drain_results();

    // parse a good sector with partition_start at its maximum, pausing halfway
    write_partition_start(32'hFFFF_FFFF);
    build_image(1'b1);
    send_sector(1, SECTOR_IMAGE_BYTES_DEF / 2);
    query_burst(16);
    drain_results();

    // second sector while the volume is valid, no sender gaps
    write_partition_start($urandom);
    steady = 1'b1;
    build_image(1'b1);
    send_sector(2, -1);
    query_burst(16);
    steady = 1'b0;
    drain_results();

    // invalidate, abort a partial parse, then a sector with a bad signature
    write_partition_start(32'd0);
    send_item(FUNC_CLEAR, 8'($urandom), 28'($urandom));
    repeat ($urandom_range(10, 40)) send_item(FUNC_BYTE, 8'($urandom), 28'($urandom));
    send_item(FUNC_CLEAR, 8'($urandom), 28'($urandom));
    build_image(1'b0);
    send_sector(1, -1);
    query_burst(12);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fbsg_pkg.sv
sv/fbsg_front.sv
sv/fbsg_queue.sv
sv/fbsg_back.sv
sv/fat32_boot_sector_geometry_top.sv
tb/fat32_geometry_checker.sv
tb/fat32_boot_sector_geometry_top_tb.sv
